@@ rtl/ifs_pkg.sv @@
// Package: types and constants for the IFS chaos-game step block
package ifs_pkg;

    localparam int COEF_BITS = 24;
    localparam int SET_COUNT = 10;
    localparam int MAP_COUNT = 51;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_PIXX,
        ST_PIXY,
        ST_DONE
    } state_t;

    // Q24 coefficients; translations reach above 2^24
    typedef struct packed {
        int a;
        int b;
        int c;
        int d;
        int e;
        int f;
    } coef_t;

    function automatic logic [5:0] set_base(input logic [3:0] sel);
        case (sel)
            4'd0: set_base = 6'd0;
            4'd1: set_base = 6'd2;
            4'd2: set_base = 6'd6;
            4'd3: set_base = 6'd9;
            4'd4: set_base = 6'd11;
            4'd5: set_base = 6'd20;
            4'd6: set_base = 6'd24;
            4'd7: set_base = 6'd27;
            4'd8: set_base = 6'd38;
            default: set_base = 6'd42;
        endcase
    endfunction

    function automatic coef_t coef_rom(input logic [5:0] i);
        coef_t k;
        case (i)
            6'd0:  k = '{8388608, 0, 0, 8388608, 0, 0};
            6'd1:  k = '{8388608, 0, 0, 8388608, 8388608, 8388608};
            6'd2:  k = '{8388608, 0, 0, 8388608, 0, 0};
            6'd3:  k = '{8388608, 0, 0, 8388608, 8388608, 0};
            6'd4:  k = '{8388608, 0, 0, 8388608, 0, 8388608};
            6'd5:  k = '{-8388608, 0, 0, -8388608, 8388608, 8388608};
            6'd6:  k = '{8388608, 0, 0, 8388608, 0, 0};
            6'd7:  k = '{8388608, 0, 0, 8388608, 8388608, 0};
            6'd8:  k = '{8388608, 0, 0, 8388608, 0, 8388608};
            6'd9:  k = '{-8388608, -8388608, 8388608, -8388608, 8388608, 8388608};
            6'd10: k = '{-8388608, 8388608, -8388608, -8388608, 8388608, 8388608};
            6'd11: k = '{5592405, 0, 0, 5592405, 0, 0};
            6'd12: k = '{5592405, 0, 0, 5592405, 5592405, 0};
            6'd13: k = '{5592405, 0, 0, 5592405, 11184811, 0};
            6'd14: k = '{5592405, 0, 0, 5592405, 0, 5592405};
            6'd15: k = '{5592405, 0, 0, 5592405, 0, 0};
            6'd16: k = '{5592405, 0, 0, 5592405, 11184811, 5592405};
            6'd17: k = '{5592405, 0, 0, 5592405, 0, 11184811};
            6'd18: k = '{5592405, 0, 0, 5592405, 5592405, 11184811};
            6'd19: k = '{5592405, 0, 0, 5592405, 11184811, 11184811};
            6'd20: k = '{5592405, 0, 0, 5592405, 0, 0};
            6'd21: k = '{2796203, -4843165, 4843165, 2796203, 5592405, 0};
            6'd22: k = '{2796203, 4843165, -4843165, 2796203, 8388608, 4843165};
            6'd23: k = '{5592405, 0, 0, 5592405, 11184811, 0};
            6'd24: k = '{8388608, 0, 0, 8388608, 0, 4194304};
            6'd25: k = '{0, -8388608, 8388608, 0, 12582912, 8388608};
            6'd26: k = '{0, 8388608, -8388608, 0, 4194304, 8388608};
            6'd27: k = '{0, -5592405, 4194304, 0, 1864135, 2097152};
            6'd28: k = '{-1186328, -1977214, 1186328, -1977214, 2796203, 4194304};
            6'd29: k = '{0, -5592405, 4194304, 0, 4660338, 2097152};
            6'd30: k = '{0, -5592405, 4194304, 0, 6524473, 2097152};
            6'd31: k = '{-787818, -3801330, 1689480, -1772589, 7922852, 4194304};
            6'd32: k = '{932068, -3632374, 1614388, 2097152, 8854919, 3670016};
            6'd33: k = '{0, -5592405, 4194304, 0, 11184811, 2097152};
            6'd34: k = '{0, -5592405, 4194304, 0, 13048946, 2097152};
            6'd35: k = '{932068, -3632374, 1614388, 2097152, 13514980, 2097152};
            6'd36: k = '{-787818, -3801330, 1689480, -1772589, 15845705, 3145728};
            6'd37: k = '{0, -5592405, 4194304, 0, 17243251, 2097152};
            6'd38: k = '{0, 0, 664810, 2531403, 8388608, -332405};
            6'd39: k = '{14228301, 665514, -665514, 14228301, 1274458, 3017112};
            6'd40: k = '{-3915082, 5095234, 5095234, 3915082, 10346149, -1876528};
            6'd41: k = '{3505052, -4393534, 4393534, 3505052, 6636082, 487588};
            6'd42: k = '{2421583, -699051, 1398101, 1210791, 5592405, 13281963};
            6'd43: k = '{2421583, 699051, -1398101, 1210791, 9087659, 14680064};
            6'd44: k = '{0, 6990507, -4194304, 0, 4893355, 14680064};
            6'd45: k = '{0, 3495253, -2796203, 0, 6990507, 11883861};
            6'd46: k = '{0, 6990507, -4194304, 0, 4893355, 10485760};
            6'd47: k = '{-2700924, -542783, 723711, -2025693, 10485760, 7340032};
            6'd48: k = '{0, 6990507, -4194304, 0, 4893355, 6990507};
            6'd49: k = '{-2421583, -1398101, 1398101, -2421583, 9087659, 3495253};
            6'd50: k = '{1977214, -1977214, 1977214, 1977214, 10485760, 629146};
            default: k = '0;
        endcase
        return k;
    endfunction

endpackage

@@ rtl/ifs_map_pick.sv @@
// Map selection: compares the random fraction against the set's thresholds
module ifs_map_pick
    import ifs_pkg::*;
#(
    parameter int RAND_BITS = 16
) (
    input  logic [3:0]           sel,
    input  logic [RAND_BITS-1:0] field,
    output logic [3:0]           idx
);
    logic [9:0]           den;
    logic [3:0]           cnt;
    logic [RAND_BITS+9:0] lhs;
    logic [RAND_BITS+9:0] rhs [10];
    logic [9:0]           num [10];

    always_comb
    begin
        case (sel)
            4'd0:    begin den = 10'd2;    cnt = 4'd1;  end
            4'd1:    begin den = 10'd4;    cnt = 4'd3;  end
            4'd2:    begin den = 10'd100;  cnt = 4'd2;  end
            4'd3:    begin den = 10'd2;    cnt = 4'd1;  end
            4'd4:    begin den = 10'd9;    cnt = 4'd8;  end
            4'd5:    begin den = 10'd4;    cnt = 4'd3;  end
            4'd6:    begin den = 10'd1000; cnt = 4'd2;  end
            4'd7:    begin den = 10'd11;   cnt = 4'd10; end
            4'd8:    begin den = 10'd4;    cnt = 4'd3;  end
            default: begin den = 10'd9;    cnt = 4'd8;  end
        endcase
        lhs = {10'd0, field} * {{RAND_BITS{1'b0}}, den};
        idx = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (sel == 4'd2)
                num[i] = (i % 2 == 0) ? 10'd33 : 10'd66;
            else if (sel == 4'd6)
                num[i] = (i % 2 == 0) ? 10'd333 : 10'd666;
            else
                num[i] = 10'(i + 1);
            rhs[i] = {num[i], {RAND_BITS{1'b0}}};
            if (4'(i) < cnt && lhs >= rhs[i])
                idx = 4'(i + 1);
        end
    end
endmodule

@@ rtl/ifs_mac.sv @@
// Shared multiply-accumulate unit: while enabled, adds one product per cycle into a registered accumulator
module ifs_mac
    import ifs_pkg::*;
(
    input  logic               clk,
    input  logic               clr,
    input  logic               en,
    input  logic signed [24:0] op_a,
    input  logic signed [24:0] op_b,
    input  logic signed [63:0] bias,
    output logic signed [63:0] acc
);
    logic signed [63:0] acc_reg;
    logic signed [63:0] acc_next;
    logic signed [49:0] prod;

    assign prod = op_a * op_b;

    always_comb
    begin
        acc_next = acc_reg;
        if (en)
            acc_next = (clr ? bias : acc_reg) + 64'(prod);
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;
endmodule

@@ rtl/ifs_chaos_game_point_step.sv @@
// Top level of the IFS chaos-game step block
// A request steps through MUL0-MUL3, PIXX, PIXY, DONE: one shared 25x25 multiplier
// forms the four map products and the two pixel products, one per cycle, in turn.
// The result register then holds until taken; a new request is accepted once it empties.
module ifs_chaos_game_point_step
    import ifs_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int RAND_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [11:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [RAND_BITS-1:0] random_fraction,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [23:0]  point_x,
    output logic signed [23:0]  point_y,
    output logic signed [15:0]  pixel_x,
    output logic signed [15:0]  pixel_y,
    output logic [3:0]          map_chosen
);
    localparam logic [0:0] REG_SELECT = 1'b0;
    localparam logic [0:0] REG_SCALE  = 1'b1;

    state_t state_reg, state_next;
    logic [3:0]  sel_reg;
    logic [11:0] scale_reg;
    logic signed [23:0] cur_x_reg, cur_y_reg, nx_reg, ny_reg;
    logic [3:0]  idx_reg, idx_pick, sel_eff;
    coef_t       k_reg;
    logic        out_valid_reg;
    logic signed [15:0] px_reg, py_reg;

    logic               mac_clr, mac_en;
    logic signed [24:0] op_a, op_b;
    logic signed [63:0] bias, acc;
    logic signed [23:0] row_sat;
    logic signed [15:0] pix_sat;
    logic               accept;

    assign accept  = in_valid && !in_stall;
    assign sel_eff = (sel_reg > 4'd9) ? 4'd9 : sel_reg;

    ifs_map_pick #(.RAND_BITS(RAND_BITS)) u_pick (
        .sel   (sel_eff),
        .field (random_fraction),
        .idx   (idx_pick)
    );

    ifs_mac u_mac (
        .clk  (clk),
        .clr  (mac_clr),
        .en   (mac_en),
        .op_a (op_a),
        .op_b (op_b),
        .bias (bias),
        .acc  (acc)
    );

    // round to FRAC_BITS, ties up, saturate to 24 bits
    logic signed [63:0] rnd;
    assign rnd = (acc + (64'sd1 <<< (COEF_BITS - 1))) >>> COEF_BITS;
    assign row_sat = (rnd > 64'sd8388607) ? 24'sh7fffff :
                     (rnd < -64'sd8388608) ? -24'sh800000 : rnd[23:0];

    // pixel: truncate toward zero
    logic signed [63:0] pq;
    assign pq = (acc < 0) ? -((-acc) >>> FRAC_BITS) : (acc >>> FRAC_BITS);
    assign pix_sat = (pq > 64'sd32767) ? 16'sh7fff :
                     (pq < -64'sd32768) ? -16'sh8000 : pq[15:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_MUL0;
            ST_MUL0: state_next = ST_MUL1;
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_MUL3;
            ST_MUL3: state_next = ST_PIXX;
            ST_PIXX: state_next = ST_PIXY;
            ST_PIXY: state_next = ST_DONE;
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        mac_en  = 1'b1;
        mac_clr = 1'b0;
        op_a    = '0;
        op_b    = '0;
        bias    = '0;
        case (state_reg)
            ST_MUL0:
            begin
                mac_clr = 1'b1;
                op_a = 25'(k_reg.a);
                op_b = 25'(cur_x_reg);
                bias = 64'(k_reg.e) <<< FRAC_BITS;
            end
            ST_MUL1:
            begin
                op_a = 25'(k_reg.b);
                op_b = 25'(cur_y_reg);
            end
            ST_MUL2:
            begin
                mac_clr = 1'b1;
                op_a = 25'(k_reg.c);
                op_b = 25'(cur_x_reg);
                bias = 64'(k_reg.f) <<< FRAC_BITS;
            end
            ST_MUL3:
            begin
                op_a = 25'(k_reg.d);
                op_b = 25'(cur_y_reg);
            end
            ST_PIXX:
            begin
                mac_clr = 1'b1;
                op_a = 25'(nx_reg);
                op_b = $signed({13'd0, scale_reg});
            end
            ST_PIXY:
            begin
                mac_clr = 1'b1;
                op_a = 25'(ny_reg);
                op_b = $signed({13'd0, scale_reg});
            end
            default: mac_en = 1'b0;
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE) || out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sel_reg       <= 4'd9;
            scale_reg     <= 12'd701;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we && cfg_index == REG_SELECT)
                sel_reg <= cfg_data[3:0];
            if (cfg_we && cfg_index == REG_SCALE)
                scale_reg <= cfg_data;
            if (state_reg == ST_DONE)
            begin
                cur_x_reg     <= nx_reg;
                cur_y_reg     <= ny_reg;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg <= idx_pick;
            k_reg   <= coef_rom(set_base(sel_eff) + 6'(idx_pick));
        end
        if (state_reg == ST_MUL2)
            nx_reg <= row_sat;
        if (state_reg == ST_PIXX)
            ny_reg <= row_sat;
        if (state_reg == ST_PIXY)
            px_reg <= pix_sat;
        if (state_reg == ST_DONE)
            py_reg <= pix_sat;
    end

    assign out_valid  = out_valid_reg;
    assign point_x    = cur_x_reg;
    assign point_y    = cur_y_reg;
    assign pixel_x    = px_reg;
    assign pixel_y    = py_reg;
    assign map_chosen = idx_reg;
endmodule

@@ rtl/ifs_checker.sv @@
// Port checker for the IFS chaos-game step block, bound to the top level
module ifs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [3:0] map_chosen
);
    a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("request accepted with result pending");
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall) else $error("not busy after request");
    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(map_chosen)))
        else $error("result dropped while stalled");
    a_map_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (map_chosen <= 4'd10)) else $error("map index out of range");
endmodule

bind ifs_chaos_game_point_step ifs_checker u_ifs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .map_chosen (map_chosen)
);

@@ dv/ifs_chaos_game_point_step_tb.sv @@
// Testbench for the IFS chaos-game step block: queued driver, checking monitor, point predictor
`timescale 1ns / 1ps

module ifs_chaos_game_point_step_tb;
    import ifs_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [0:0] REG_SELECT = 1'b0;
    localparam logic [0:0] REG_SCALE = 1'b1;
    localparam int SIERPINSKI = 2;
    localparam int TREK = 6;
    localparam int MIO = 9;

    typedef struct {
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [15:0] hx;
        logic signed [15:0] hy;
        logic [3:0]         map;
    } point_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [0:0] cfg_index = REG_SELECT;
    logic [11:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [15:0] random_fraction = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic [3:0] map_chosen;

    ifs_chaos_game_point_step DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .random_fraction(random_fraction),
        .out_valid(out_valid), .out_stall(out_stall),
        .point_x(point_x), .point_y(point_y), .pixel_x(pixel_x), .pixel_y(pixel_y),
        .map_chosen(map_chosen)
    );

    always #6 clk = ~clk;

    // affine maps a, b, c, d, e, f in Q24
    int map_coef [51][6] = '{
        '{8388608, 0, 0, 8388608, 0, 0},
        '{8388608, 0, 0, 8388608, 8388608, 8388608},
        '{8388608, 0, 0, 8388608, 0, 0},
        '{8388608, 0, 0, 8388608, 8388608, 0},
        '{8388608, 0, 0, 8388608, 0, 8388608},
        '{-8388608, 0, 0, -8388608, 8388608, 8388608},
        '{8388608, 0, 0, 8388608, 0, 0},
        '{8388608, 0, 0, 8388608, 8388608, 0},
        '{8388608, 0, 0, 8388608, 0, 8388608},
        '{-8388608, -8388608, 8388608, -8388608, 8388608, 8388608},
        '{-8388608, 8388608, -8388608, -8388608, 8388608, 8388608},
        '{5592405, 0, 0, 5592405, 0, 0},
        '{5592405, 0, 0, 5592405, 5592405, 0},
        '{5592405, 0, 0, 5592405, 11184811, 0},
        '{5592405, 0, 0, 5592405, 0, 5592405},
        '{5592405, 0, 0, 5592405, 0, 0},
        '{5592405, 0, 0, 5592405, 11184811, 5592405},
        '{5592405, 0, 0, 5592405, 0, 11184811},
        '{5592405, 0, 0, 5592405, 5592405, 11184811},
        '{5592405, 0, 0, 5592405, 11184811, 11184811},
        '{5592405, 0, 0, 5592405, 0, 0},
        '{2796203, -4843165, 4843165, 2796203, 5592405, 0},
        '{2796203, 4843165, -4843165, 2796203, 8388608, 4843165},
        '{5592405, 0, 0, 5592405, 11184811, 0},
        '{8388608, 0, 0, 8388608, 0, 4194304},
        '{0, -8388608, 8388608, 0, 12582912, 8388608},
        '{0, 8388608, -8388608, 0, 4194304, 8388608},
        '{0, -5592405, 4194304, 0, 1864135, 2097152},
        '{-1186328, -1977214, 1186328, -1977214, 2796203, 4194304},
        '{0, -5592405, 4194304, 0, 4660338, 2097152},
        '{0, -5592405, 4194304, 0, 6524473, 2097152},
        '{-787818, -3801330, 1689480, -1772589, 7922852, 4194304},
        '{932068, -3632374, 1614388, 2097152, 8854919, 3670016},
        '{0, -5592405, 4194304, 0, 11184811, 2097152},
        '{0, -5592405, 4194304, 0, 13048946, 2097152},
        '{932068, -3632374, 1614388, 2097152, 13514980, 2097152},
        '{-787818, -3801330, 1689480, -1772589, 15845705, 3145728},
        '{0, -5592405, 4194304, 0, 17243251, 2097152},
        '{0, 0, 664810, 2531403, 8388608, -332405},
        '{14228301, 665514, -665514, 14228301, 1274458, 3017112},
        '{-3915082, 5095234, 5095234, 3915082, 10346149, -1876528},
        '{3505052, -4393534, 4393534, 3505052, 6636082, 487588},
        '{2421583, -699051, 1398101, 1210791, 5592405, 13281963},
        '{2421583, 699051, -1398101, 1210791, 9087659, 14680064},
        '{0, 6990507, -4194304, 0, 4893355, 14680064},
        '{0, 3495253, -2796203, 0, 6990507, 11883861},
        '{0, 6990507, -4194304, 0, 4893355, 10485760},
        '{-2700924, -542783, 723711, -2025693, 10485760, 7340032},
        '{0, 6990507, -4194304, 0, 4893355, 6990507},
        '{-2421583, -1398101, 1398101, -2421583, 9087659, 3495253},
        '{1977214, -1977214, 1977214, 1977214, 10485760, 629146}
    };
    int first_map [10] = '{0, 2, 6, 9, 11, 20, 24, 27, 38, 42};
    int thr_den [10] = '{2, 4, 100, 2, 9, 4, 1000, 11, 4, 9};
    int thr_cnt [10] = '{1, 3, 2, 1, 8, 3, 2, 10, 3, 8};

    logic [3:0] sel_reg = 4'd9;
    logic [11:0] scale_reg = 12'd701;
    logic signed [23:0] walk_x = '0;
    logic signed [23:0] walk_y = '0;

    logic [15:0] request_q [$];
    point_t pending_points [$];
    int idle_pct = 0;
    int stall_pct = 0;
    int mismatches = 0;
    int checked = 0;
    int cycles = 0;

    function automatic longint thr_num(int sel, int i);
        if (sel == SIERPINSKI)
            return (i == 0) ? 33 : 66;
        if (sel == TREK)
            return (i == 0) ? 333 : 666;
        return i + 1;
    endfunction

    function automatic logic signed [23:0] affine_row(longint k1, longint k2, longint t);
        longint acc;
        acc = k1 * walk_x + k2 * walk_y + (t <<< 16) + (longint'(1) <<< 23);
        acc = acc >>> 24;
        if (acc > 8388607)
            acc = 8388607;
        if (acc < -8388608)
            acc = -8388608;
        return acc[23:0];
    endfunction

    function automatic logic signed [15:0] pixel_of(logic signed [23:0] p);
        longint prod;
        longint q;
        prod = longint'(p) * longint'(scale_reg);
        q = (prod >= 0) ? (prod >>> 16) : -((-prod) >>> 16);
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return q[15:0];
    endfunction

    function automatic point_t next_point(logic [15:0] frac);
        point_t r;
        int sel;
        int idx;
        int m;
        sel = (sel_reg > MIO) ? MIO : sel_reg;
        idx = 0;
        for (int i = 0; i < thr_cnt[sel]; i++)
            if (longint'(frac) * thr_den[sel] >= (thr_num(sel, i) <<< 16))
                idx = i + 1;
        m = first_map[sel] + idx;
        r.px = affine_row(map_coef[m][0], map_coef[m][1], map_coef[m][4]);
        r.py = affine_row(map_coef[m][2], map_coef[m][3], map_coef[m][5]);
        r.hx = pixel_of(r.px);
        r.hy = pixel_of(r.py);
        r.map = idx[3:0];
        walk_x = r.px;
        walk_y = r.py;
        return r;
    endfunction

    task automatic report(string field, longint got, longint want);
        mismatches++;
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
                pending_points.push_back(next_point(random_fraction));
            if (request_q.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                random_fraction <= request_q.pop_front();
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        point_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            checked++;
            if (pending_points.size() == 0)
            begin
                report("unexpected result", 0, 0);
            end
            else
            begin
                e = pending_points.pop_front();
                if (point_x !== e.px) report("point_x", point_x, e.px);
                if (point_y !== e.py) report("point_y", point_y, e.py);
                if (pixel_x !== e.hx) report("pixel_x", pixel_x, e.hx);
                if (pixel_y !== e.hy) report("pixel_y", pixel_y, e.hy);
                if (map_chosen !== e.map) report("map_chosen", map_chosen, e.map);
            end
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("ifs_chaos_game_point_step_tb NOT OK");
            $finish;
        end
    end

    task automatic drain();
        while (request_q.size() > 0 || in_valid || pending_points.size() > 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_cfg(logic [3:0] sel, logic [11:0] scale);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_SELECT;
        cfg_data <= {8'hA5 & {8{sel[0]}}, sel};
        @(posedge clk);
        cfg_index <= REG_SCALE;
        cfg_data <= scale;
        @(posedge clk);
        cfg_we <= 1'b0;
        sel_reg = sel;
        scale_reg = scale;
    endtask

    task automatic push_boundaries(int sel);
        longint b;
        for (int i = 0; i < thr_cnt[sel]; i++)
        begin
            b = ((thr_num(sel, i) <<< 16) + thr_den[sel] - 1) / thr_den[sel];
            request_q.push_back(16'(b - 1));
            request_q.push_back(16'(b));
        end
    endtask

    initial
    begin
        logic [11:0] scale;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings first, then threshold edges of the uneven sets
        request_q.push_back(16'h0000);
        request_q.push_back(16'hFFFF);
        request_q.push_back(16'h5555);
        request_q.push_back(16'hAAAA);
        push_boundaries(MIO);
        drain();
        write_cfg(4'(SIERPINSKI), 12'd4095);
        push_boundaries(SIERPINSKI);
        drain();
        write_cfg(4'(TREK), 12'd1);
        push_boundaries(TREK);
        drain();

        for (int p = 0; p < 16; p++)
        begin
            case (p % 4)
                0: begin idle_pct = 0; stall_pct = 0; end
                1: begin idle_pct = 71; stall_pct = 0; end
                2: begin idle_pct = 0; stall_pct = 71; end
                default: begin idle_pct = 33; stall_pct = 33; end
            endcase
            case (p)
                0: scale = 12'd1;
                1: scale = 12'd4095;
                3: scale = 12'd0;
                7: scale = 12'hFFF;
                default: scale = 12'($urandom_range(4095));
            endcase
            write_cfg(4'(p), scale);
            for (int n = 0; n < 26; n++)
            begin
                if ($urandom_range(9) == 0)
                    push_boundaries(p > MIO ? MIO : p);
                else
                    request_q.push_back(16'($urandom_range(65535)));
            end
            drain();
        end

        $display("checked %0d results over all 16 map-set selections", checked);
        $display("plot scales 0, 1 and 4095 and all four idle/stall mixes covered");
        if (mismatches == 0)
            $display("ifs_chaos_game_point_step_tb OK");
        else
            $display("ifs_chaos_game_point_step_tb NOT OK");
        $finish;
    end

endmodule
